// File: hw/rtl/ucd_pkg.sv
// ucd_pkg: shared types and constants for the utf-8 stream decoder
// no dependencies; imported by ucd_front, ucd_result_q and the top level
package ucd_pkg;

  localparam int unsigned CP_W   = 21;
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [CP_W-1:0] REPL_CP    = 21'h00FFFD;
  localparam logic [CP_W-1:0] MAX_CP     = 21'h10FFFF;
  localparam logic [CP_W-1:0] SURR_LO    = 21'h00D800;
  localparam logic [CP_W-1:0] SURR_HI    = 21'h00DFFF;
  localparam logic [CP_W-1:0] MAX_ASCII  = 21'h00007F;
  localparam logic [CP_W-1:0] MAX_2BYTE  = 21'h0007FF;
  localparam logic [CP_W-1:0] MAX_3BYTE  = 21'h00FFFF;

  localparam logic [7:0] MASK_2LEAD = 8'hE0;
  localparam logic [7:0] TAG_2LEAD  = 8'hC0;
  localparam logic [7:0] MASK_3LEAD = 8'hF0;
  localparam logic [7:0] TAG_3LEAD  = 8'hE0;
  localparam logic [7:0] MASK_4LEAD = 8'hF8;
  localparam logic [7:0] TAG_4LEAD  = 8'hF0;
  localparam logic [7:0] MASK_CONT  = 8'hC0;
  localparam logic [7:0] TAG_CONT   = 8'h80;
  localparam logic [7:0] CONT_BITS  = 8'h3F;
  localparam logic [7:0] TERM_BYTE  = 8'h00;

  localparam logic [2:0] SEQ_LEN2 = 3'd2;
  localparam logic [2:0] SEQ_LEN3 = 3'd3;
  localparam logic [2:0] SEQ_LEN4 = 3'd4;

  typedef struct packed {
    logic [CP_W-1:0] code_point;
    logic            bad;
    logic            end_of_string;
    logic            all_valid;
    logic            last_of_run;
  } ucd_result_t;

  // up to two results per byte, slot 1 only used together with slot 0
  typedef struct packed {
    logic        v0;
    logic        v1;
    ucd_result_t r0;
    ucd_result_t r1;
  } ucd_push_t;

  // outcome of handling a byte with no sequence open
  typedef struct packed {
    logic            has_res;
    ucd_result_t     res;
    logic            opens;
    logic            term;
    logic [CP_W-1:0] pv;
    logic [2:0]      len;
  } ucd_start_t;

endpackage

// File: hw/rtl/ucd_front.sv
// ucd_front: accepts bytes, tracks the open sequence and forms result items
// depends on ucd_pkg
module ucd_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic [7:0]        in_byte,
  output ucd_pkg::ucd_push_t push
);
  import ucd_pkg::*;

  logic [CP_W-1:0] pv_r, pv_nxt;
  logic [1:0]      rem_r, rem_nxt;
  logic [2:0]      len_r, len_nxt;
  logic            err_r, err_nxt;

  logic            cont;
  logic [CP_W-1:0] shifted;
  logic            reject;
  ucd_start_t      st;

  function automatic ucd_start_t start_byte(input logic [7:0] b, input logic err);
    ucd_start_t s;
    s = '0;
    if (b == TERM_BYTE) begin
      s.has_res = 1'b1;
      s.term    = 1'b1;
      s.res     = '{code_point: '0, bad: 1'b0, end_of_string: 1'b1,
                    all_valid: !err, last_of_run: 1'b1};
    end else if (!b[7]) begin
      s.has_res = 1'b1;
      s.res     = '{code_point: {13'd0, b}, bad: 1'b0, end_of_string: 1'b0,
                    all_valid: 1'b0, last_of_run: 1'b1};
    end else if ((b & MASK_2LEAD) == TAG_2LEAD) begin
      s.opens = 1'b1;
      s.pv    = {16'd0, b[4:0]};
      s.len   = SEQ_LEN2;
    end else if ((b & MASK_3LEAD) == TAG_3LEAD) begin
      s.opens = 1'b1;
      s.pv    = {17'd0, b[3:0]};
      s.len   = SEQ_LEN3;
    end else if ((b & MASK_4LEAD) == TAG_4LEAD) begin
      s.opens = 1'b1;
      s.pv    = {18'd0, b[2:0]};
      s.len   = SEQ_LEN4;
    end else begin
      s.has_res = 1'b1;
      s.res     = '{code_point: REPL_CP, bad: 1'b1, end_of_string: 1'b0,
                    all_valid: 1'b0, last_of_run: 1'b1};
    end
    return s;
  endfunction

  assign cont    = (in_byte & MASK_CONT) == TAG_CONT;
  assign shifted = {pv_r[CP_W-7:0], in_byte[5:0] & CONT_BITS[5:0]};

  // overlong, surrogate or out of range
  assign reject = (shifted <= MAX_ASCII) ||
                  ((shifted <= MAX_2BYTE) && (len_r > SEQ_LEN2)) ||
                  ((shifted <= MAX_3BYTE) && (len_r > SEQ_LEN3)) ||
                  ((shifted >= SURR_LO) && (shifted <= SURR_HI)) ||
                  (shifted > MAX_CP);

  // a broken sequence always flags an error ahead of the reprocessed byte
  assign st = start_byte(in_byte, err_r | (rem_r != 2'd0));

  always_comb begin
    pv_nxt  = pv_r;
    rem_nxt = rem_r;
    len_nxt = len_r;
    push    = '0;
    if (accept) begin
      if (rem_r == 2'd0) begin
        push.v0 = st.has_res;
        push.r0 = st.res;
        if (st.opens) begin
          pv_nxt  = st.pv;
          len_nxt = st.len;
          rem_nxt = 2'(st.len - 3'd1);
        end
      end else if (cont) begin
        rem_nxt = rem_r - 2'd1;
        if (rem_r == 2'd1) begin
          push.v0 = 1'b1;
          push.r0 = '{code_point: reject ? REPL_CP : shifted, bad: reject,
                      end_of_string: 1'b0, all_valid: 1'b0, last_of_run: 1'b1};
          pv_nxt  = '0;
          len_nxt = '0;
        end else begin
          pv_nxt = shifted;
        end
      end else begin
        push.v0 = 1'b1;
        push.r0 = '{code_point: REPL_CP, bad: 1'b1, end_of_string: 1'b0,
                    all_valid: 1'b0, last_of_run: !st.has_res};
        push.v1 = st.has_res;
        push.r1 = st.res;
        pv_nxt  = '0;
        rem_nxt = '0;
        len_nxt = '0;
        if (st.opens) begin
          pv_nxt  = st.pv;
          len_nxt = st.len;
          rem_nxt = 2'(st.len - 3'd1);
        end
      end
      if (!cont && st.term) begin
        pv_nxt  = '0;
        rem_nxt = '0;
        len_nxt = '0;
      end
    end
  end

  always_comb begin
    err_nxt = err_r | (push.v0 & push.r0.bad) | (push.v1 & push.r1.bad);
    if ((push.v0 && push.r0.end_of_string) || (push.v1 && push.r1.end_of_string)) begin
      err_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r  <= '0;
      rem_r <= '0;
      len_r <= '0;
      err_r <= 1'b0;
    end else begin
      pv_r  <= pv_nxt;
      rem_r <= rem_nxt;
      len_r <= len_nxt;
      err_r <= err_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_open_len: assert property (@(posedge clk) disable iff (!rst_n)
    (rem_r != 2'd0) |-> ((len_r >= SEQ_LEN2) && (len_r <= SEQ_LEN4) &&
                         ({1'b0, rem_r} < len_r)))
    else $error("open sequence with inconsistent length");
  a_term_clears: assert property (@(posedge clk) disable iff (!rst_n)
    ((push.v0 && push.r0.end_of_string) || (push.v1 && push.r1.end_of_string))
      |=> (rem_r == 2'd0) && !err_r)
    else $error("terminator did not clear decode state");
  a_two_results: assert property (@(posedge clk) disable iff (!rst_n)
    push.v1 |-> (push.v0 && push.r0.bad && !push.r0.last_of_run))
    else $error("second result without a broken-sequence replacement");
`endif

endmodule

// File: hw/rtl/ucd_result_q.sv
// ucd_result_q: short result queue taking up to two items a cycle, one out
// depends on ucd_pkg
module ucd_result_q (
  input  logic                clk,
  input  logic                rst_n,
  input  ucd_pkg::ucd_push_t  push,
  input  logic                pop,
  output logic                full,
  output logic                empty,
  output ucd_pkg::ucd_result_t head
);
  import ucd_pkg::*;

  ucd_result_t       ent_r [QDEPTH];
  logic [QPTR_W-1:0] wr_r, wr_nxt;
  logic [QPTR_W-1:0] rd_r, rd_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic [1:0]        n_in;
  logic              deq;

  assign n_in  = {1'b0, push.v0} + {1'b0, push.v1};
  assign empty = (cnt_r == '0);
  // room for a worst-case byte is kept before a byte is taken
  assign full  = (cnt_r > QCNT_W'(QDEPTH - 2));
  assign deq   = pop && !empty;
  assign head  = ent_r[rd_r];

  always_comb begin
    wr_nxt  = wr_r + QPTR_W'(n_in);
    rd_nxt  = rd_r + QPTR_W'(deq);
    cnt_nxt = cnt_r + QCNT_W'(n_in) - QCNT_W'(deq);
  end

  always_ff @(posedge clk) begin
    if (push.v0) begin
      ent_r[wr_r] <= push.r0;
    end
    if (push.v1) begin
      ent_r[wr_r + QPTR_W'(1)] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCNT_W'(QDEPTH))
    else $error("result queue overflow");
  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    QPTR_W'(wr_r - rd_r) == cnt_r[QPTR_W-1:0])
    else $error("queue pointers disagree with fill count");
  a_push_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    push.v0 |-> ($past(cnt_r) == $past(cnt_r)) && (cnt_r <= QCNT_W'(QDEPTH - 2)))
    else $error("push while the queue lacks room");
`endif

endmodule

// File: hw/rtl/utf8_stream_decoder_validator.sv
// utf8_stream_decoder_validator: top level, byte front end feeding a result queue
// depends on ucd_pkg, ucd_front, ucd_result_q
//
//   channel  | direction | handshake             | payload
//   ---------+-----------+-----------------------+--------------------------------------
//   in_      | in        | in_push / in_full     | in_byte
//   out_     | out       | out_empty / out_pop   | out_code_point, out_bad,
//            |           |                       | out_end_of_string, out_all_valid,
//            |           |                       | out_last_of_run
//
// one byte is decoded per cycle while in_full is low; each result is registered in the queue
// a byte that breaks a sequence gives up to two results, the queue drains one a cycle while out_pop is high
// in_full rises when the four-entry result queue holds more than two results
// rst_n is synchronous and clears the decode state and the queue
module utf8_stream_decoder_validator (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_push,
  output logic                      in_full,
  input  logic [7:0]                in_byte,
  output logic                      out_empty,
  input  logic                      out_pop,
  output logic [ucd_pkg::CP_W-1:0]  out_code_point,
  output logic                      out_bad,
  output logic                      out_end_of_string,
  output logic                      out_all_valid,
  output logic                      out_last_of_run
);
  import ucd_pkg::*;

  logic        accept;
  ucd_push_t   push;
  ucd_result_t head;

  assign accept = in_push && !in_full;

  ucd_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .in_byte (in_byte),
    .push    (push)
  );

  ucd_result_q u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (out_pop),
    .full  (in_full),
    .empty (out_empty),
    .head  (head)
  );

  assign out_code_point    = head.code_point;
  assign out_bad           = head.bad;
  assign out_end_of_string = head.end_of_string;
  assign out_all_valid     = head.all_valid;
  assign out_last_of_run   = head.last_of_run;

endmodule

// File: dv/utf8_stream_decoder_validator_test.sv
`timescale 1ns / 1ps
// utf8_stream_decoder_validator_test: self-checking bench for the utf-8 decoder
// holds a scoreboard class with its own decoder, plus the tasks that drive the block
// depends on ucd_pkg and utf8_stream_decoder_validator
module utf8_stream_decoder_validator_test;
  import ucd_pkg::*;

  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned DRAIN_WAIT  = 20;
  localparam int unsigned RANDOM_BYTES = 750;

  localparam logic [CP_W-1:0] REPLACEMENT = 21'h00FFFD;
  localparam logic [CP_W-1:0] TOP_CP      = 21'h10FFFF;
  localparam logic [CP_W-1:0] SURR_FIRST  = 21'h00D800;
  localparam logic [CP_W-1:0] SURR_LAST   = 21'h00DFFF;

  class code_point_board;
    ucd_result_t     due_results[$];
    logic [CP_W-1:0] gathered;
    logic [1:0]      still_needed;
    logic [2:0]      seq_bytes;
    bit              string_had_error;
    int unsigned     mismatches;

    function new();
      gathered         = '0;
      still_needed     = '0;
      seq_bytes        = '0;
      string_had_error = 1'b0;
      mismatches       = 0;
    endfunction

    function void emit(logic [CP_W-1:0] cp, logic bad, logic eos, logic valid,
                       logic last);
      ucd_result_t r;
      r.code_point    = cp;
      r.bad           = bad;
      r.end_of_string = eos;
      r.all_valid     = valid;
      r.last_of_run   = last;
      due_results.push_back(r);
      if (bad) string_had_error = 1'b1;
    endfunction

    static function bit is_lead(logic [7:0] b);
      return (b[7:5] == 3'b110) || (b[7:4] == 4'b1110) || (b[7:3] == 5'b11110);
    endfunction

    // byte seen with no sequence open
    function void open_byte(logic [7:0] b);
      if (b == 8'h00) begin
        emit('0, 1'b0, 1'b1, !string_had_error, 1'b1);
        gathered         = '0;
        still_needed     = '0;
        seq_bytes        = '0;
        string_had_error = 1'b0;
      end else if (b[7] == 1'b0) begin
        emit({13'd0, b}, 1'b0, 1'b0, 1'b0, 1'b1);
      end else if (b[7:5] == 3'b110) begin
        gathered     = {16'd0, b[4:0]};
        seq_bytes    = 3'd2;
        still_needed = 2'd1;
      end else if (b[7:4] == 4'b1110) begin
        gathered     = {17'd0, b[3:0]};
        seq_bytes    = 3'd3;
        still_needed = 2'd2;
      end else if (b[7:3] == 5'b11110) begin
        gathered     = {18'd0, b[2:0]};
        seq_bytes    = 3'd4;
        still_needed = 2'd3;
      end else begin
        emit(REPLACEMENT, 1'b1, 1'b0, 1'b0, 1'b1);
      end
    endfunction

    function void decode_byte(logic [7:0] b);
      logic [CP_W-1:0] cp;
      bit              reject;
      if (still_needed == 2'd0) begin
        open_byte(b);
      end else if (b[7:6] == 2'b10) begin
        gathered     = {gathered[CP_W-7:0], b[5:0]};
        still_needed = still_needed - 2'd1;
        if (still_needed == 2'd0) begin
          cp     = gathered;
          reject = (cp <= 21'h7F) || (cp <= 21'h7FF && seq_bytes > 3'd2) ||
                   (cp <= 21'hFFFF && seq_bytes > 3'd3) ||
                   (cp >= SURR_FIRST && cp <= SURR_LAST) || (cp > TOP_CP);
          gathered  = '0;
          seq_bytes = '0;
          if (reject) emit(REPLACEMENT, 1'b1, 1'b0, 1'b0, 1'b1);
          else        emit(cp, 1'b0, 1'b0, 1'b0, 1'b1);
        end
      end else begin
        // broken sequence: replacement first, then the byte starts afresh
        gathered     = '0;
        still_needed = '0;
        seq_bytes    = '0;
        emit(REPLACEMENT, 1'b1, 1'b0, 1'b0, is_lead(b));
        open_byte(b);
      end
    endfunction

    function void check_result(ucd_result_t got);
      ucd_result_t want;
      if (due_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: cp=%06h bad=%b eos=%b valid=%b last=%b",
                   got.code_point, got.bad, got.end_of_string, got.all_valid,
                   got.last_of_run);
        return;
      end
      want = due_results.pop_front();
      if (got.code_point !== want.code_point || got.bad !== want.bad ||
          got.end_of_string !== want.end_of_string ||
          got.all_valid !== want.all_valid || got.last_of_run !== want.last_of_run) begin
        mismatches++;
        if (mismatches <= 10) begin
          $write("mismatch: expected cp=%06h bad=%b eos=%b valid=%b last=%b,",
                 want.code_point, want.bad, want.end_of_string, want.all_valid,
                 want.last_of_run);
          $display(" got cp=%06h bad=%b eos=%b valid=%b last=%b",
                   got.code_point, got.bad, got.end_of_string,
                   got.all_valid, got.last_of_run);
        end
      end
    endfunction
  endclass

  logic            clk;
  logic            rst_n;
  logic            in_push;
  logic            in_full;
  logic [7:0]      in_byte;
  logic            out_empty;
  logic            out_pop;
  logic [CP_W-1:0] out_code_point;
  logic            out_bad;
  logic            out_end_of_string;
  logic            out_all_valid;
  logic            out_last_of_run;

  code_point_board board;
  int unsigned     send_idle_pct;
  int unsigned     pop_stall_pct;
  int unsigned     sent_bytes;
  int unsigned     quiet_cycles;
  bit              running;

  utf8_stream_decoder_validator uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_push           (in_push),
    .in_full           (in_full),
    .in_byte           (in_byte),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_code_point    (out_code_point),
    .out_bad           (out_bad),
    .out_end_of_string (out_end_of_string),
    .out_all_valid     (out_all_valid),
    .out_last_of_run   (out_last_of_run)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  always @(negedge clk) begin
    out_pop = running && ($urandom_range(99) >= pop_stall_pct);
  end

  always @(posedge clk) begin
    ucd_result_t got;
    if (running && out_pop && !out_empty) begin
      got.code_point    = out_code_point;
      got.bad           = out_bad;
      got.end_of_string = out_end_of_string;
      got.all_valid     = out_all_valid;
      got.last_of_run   = out_last_of_run;
      board.check_result(got);
    end
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if (running) begin
      if ((in_push && !in_full) || (out_pop && !out_empty)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic push_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_push = 1'b0;
      @(negedge clk);
    end
    in_push = 1'b1;
    in_byte = b;
    @(posedge clk);
    while (in_full) @(posedge clk);
    board.decode_byte(b);
    sent_bytes++;
    @(negedge clk);
  endtask

  task automatic push_cp(input logic [CP_W-1:0] cp);
    if (cp < 21'h800) begin
      push_byte({3'b110, cp[10:6]});
    end else if (cp < 21'h10000) begin
      push_byte({4'b1110, cp[15:12]});
      push_byte({2'b10, cp[11:6]});
    end else begin
      push_byte({5'b11110, cp[20:18]});
      push_byte({2'b10, cp[17:12]});
      push_byte({2'b10, cp[11:6]});
    end
    push_byte({2'b10, cp[5:0]});
  endtask

  task automatic push_random_chunk();
    int unsigned kind;
    int unsigned tail;
    logic [7:0]  lead;
    logic [7:0]  breaker;
    kind = $urandom_range(99);
    lead = 8'($urandom_range(8'hF7, 8'hC0));
    tail = (lead >= 8'hF0) ? 3 : (lead >= 8'hE0) ? 2 : 1;
    if (kind < 25) begin
      push_byte(8'($urandom_range(8'h7F, 8'h01)));
    end else if (kind < 40) begin
      push_cp(CP_W'($urandom_range(21'h7FF, 21'h80)));
    end else if (kind < 55) begin
      push_cp(CP_W'($urandom_range(21'hFFFF, 21'h800)));
    end else if (kind < 65) begin
      push_cp(CP_W'($urandom_range(TOP_CP, 21'h10000)));
    end else if (kind < 73) begin
      // any payload bits: reaches overlong and out of range forms
      push_byte(lead);
      repeat (tail) push_byte(8'h80 | 8'($urandom_range(63)));
    end else if (kind < 81) begin
      // cut short and broken by a non-continuation byte
      push_byte(lead);
      repeat ($urandom_range(tail - 1)) push_byte(8'h80 | 8'($urandom_range(63)));
      breaker = 8'($urandom_range(255));
      if (breaker[7:6] == 2'b10) breaker[6] = 1'b1;
      push_byte(breaker);
    end else if (kind < 91) begin
      push_byte(8'($urandom_range(255)));
    end else if (kind < 96) begin
      push_byte(8'h00);
    end else begin
      push_cp(CP_W'($urandom_range(SURR_LAST, SURR_FIRST)));
    end
  endtask

  initial begin
    logic [7:0]  opening[$];
    int unsigned send_pct[4];
    int unsigned pop_pct[4];
    int unsigned phase_end;
    // ascii, 2/3/4 byte, clean terminator, overlong, surrogate, out of range,
    // bad leads, broken by ascii, broken by a new lead, zero inside a sequence
    opening = '{8'h7F, 8'h01, 8'hC3, 8'hA9, 8'hE2, 8'h82, 8'hAC, 8'hF4, 8'h8F,
                8'hBF, 8'hBF, 8'h00, 8'hC0, 8'h80, 8'hED, 8'hA0, 8'h80, 8'hF4,
                8'h90, 8'h80, 8'h80, 8'hFF, 8'h80, 8'hF8, 8'hC3, 8'h41, 8'hE2,
                8'hC3, 8'hA9, 8'hE2, 8'h00};
    send_pct = '{0, 50, 0, 34};
    pop_pct  = '{0, 0, 50, 34};
    board         = new();
    rst_n         = 1'b0;
    in_push       = 1'b0;
    in_byte       = 8'h00;
    out_pop       = 1'b0;
    running       = 1'b0;
    send_idle_pct = 0;
    pop_stall_pct = 0;
    sent_bytes    = 0;
    quiet_cycles  = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n   = 1'b1;
    running = 1'b1;

    foreach (opening[i]) push_byte(opening[i]);

    for (int p = 0; p < 4; p++) begin
      send_idle_pct = send_pct[p];
      pop_stall_pct = pop_pct[p];
      phase_end = opening.size() + (RANDOM_BYTES * (p + 1)) / 4;
      while (sent_bytes < phase_end) push_random_chunk();
    end
    in_push = 1'b0;

    while (board.due_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (board.mismatches == 0 && board.due_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
